>>> hdl/fds_pkg.sv
// Shared types, codes and constants for the FAT32 directory entry search.
`timescale 1ns / 1ps

package fds_pkg;

    // Result status codes
    localparam logic [2:0] STATUS_SKIPPED   = 3'd0;
    localparam logic [2:0] STATUS_FOUND     = 3'd1;
    localparam logic [2:0] STATUS_LISTED    = 3'd2;
    localparam logic [2:0] STATUS_END       = 3'd3;
    localparam logic [2:0] STATUS_EXHAUSTED = 3'd4;
    localparam logic [2:0] STATUS_CLOSED    = 3'd5;

    // Search modes
    localparam logic [1:0] MODE_ORDINAL = 2'd0;
    localparam logic [1:0] MODE_FILE    = 2'd1;
    localparam logic [1:0] MODE_PREFIX  = 2'd2;
    localparam logic [1:0] MODE_LIST    = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_SEARCH_MODE   = 3'd0;
    localparam logic [2:0] CFG_TARGET_INDEX  = 3'd1;
    localparam logic [2:0] CFG_TARGET_NAME   = 3'd2;
    localparam logic [2:0] CFG_TARGET_EXT    = 3'd3;
    localparam logic [2:0] CFG_PREFIX_LENGTH = 3'd4;

    localparam int          CFG_INDEX_W      = 3;
    localparam int          CFG_DATA_W       = 64;
    localparam logic [3:0]  PREFIX_RESET     = 4'd8;

    localparam logic [7:0]  DELETED_MARK     = 8'hE5;
    localparam logic [7:0]  END_MARK         = 8'h00;
    localparam logic [7:0]  ATTR_KIND_MASK   = 8'h0F;
    localparam int          ATTR_DIR_BIT     = 4;

    typedef struct packed {
        logic [1:0]  search_mode;
        logic [14:0] target_index;
        logic [63:0] target_name;
        logic [23:0] target_ext;
        logic [3:0]  prefix_length;
    } t_cfg;

    typedef struct packed {
        logic        start_search;
        logic        last_in_directory;
        logic [63:0] entry_name;
        logic [23:0] entry_ext;
        logic [7:0]  entry_attrib;
        logic [15:0] cluster_high;
        logic [15:0] cluster_low;
        logic [31:0] entry_size;
    } t_entry;

    typedef struct packed {
        logic [15:0] entry_counter;
        logic [31:0] byte_total;
        logic        search_closed;
    } t_state;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] first_cluster;
        logic [31:0] file_size;
        logic        is_directory;
        logic [15:0] entries_counted;
        logic [31:0] total_bytes;
    } t_result;

endpackage

>>> hdl/fds_entry_if.sv
// Input channel carrying one directory entry word.
`timescale 1ns / 1ps

interface fds_entry_if;
    logic        valid;
    logic        ready;
    logic        start_search;
    logic        last_in_directory;
    logic [63:0] entry_name;
    logic [23:0] entry_ext;
    logic [7:0]  entry_attrib;
    logic [15:0] cluster_high;
    logic [15:0] cluster_low;
    logic [31:0] entry_size;

    modport source (
        output valid, start_search, last_in_directory, entry_name, entry_ext,
               entry_attrib, cluster_high, cluster_low, entry_size,
        input  ready
    );
    modport sink (
        input  valid, start_search, last_in_directory, entry_name, entry_ext,
               entry_attrib, cluster_high, cluster_low, entry_size,
        output ready
    );
endinterface

>>> hdl/fds_result_if.sv
// Output channel carrying one search result word.
`timescale 1ns / 1ps

interface fds_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] first_cluster;
    logic [31:0] file_size;
    logic        is_directory;
    logic [15:0] entries_counted;
    logic [31:0] total_bytes;

    modport source (
        output valid, status, first_cluster, file_size, is_directory,
               entries_counted, total_bytes,
        input  ready
    );
    modport sink (
        input  valid, status, first_cluster, file_size, is_directory,
               entries_counted, total_bytes,
        output ready
    );
endinterface

>>> hdl/fds_eval.sv
// Combinational evaluation of one directory entry against the search state.
`timescale 1ns / 1ps

module fds_eval (
    input  fds_pkg::t_cfg    i_cfg,
    input  fds_pkg::t_state  i_state,
    input  fds_pkg::t_entry  i_entry,
    output fds_pkg::t_state  o_state,
    output fds_pkg::t_result o_result
);
    import fds_pkg::*;

    t_state      cur;
    logic [7:0]  first_byte;
    logic        counted;
    logic        is_dir;
    logic [15:0] cnt_inc;
    logic [31:0] total_inc;
    logic        match;
    logic        report;
    logic [7:0]  byte_ok;

    assign first_byte = i_entry.entry_name[63:56];
    assign is_dir     = i_entry.entry_attrib[ATTR_DIR_BIT];
    assign counted    = (first_byte != DELETED_MARK)
                     && ((i_entry.entry_attrib & ATTR_KIND_MASK) == 8'h00);

    // Start clears the state before this word is handled
    always_comb begin
        if (i_entry.start_search) begin
            cur = '0;
        end else begin
            cur = i_state;
        end
    end

    assign cnt_inc   = cur.entry_counter + 16'd1;
    assign total_inc = cur.byte_total + i_entry.entry_size;

    // Byte i of the name takes part when it lies inside the prefix
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            byte_ok[i] = (i_cfg.prefix_length <= 4'(i))
                      || (i_entry.entry_name[63 - 8 * i -: 8]
                          == i_cfg.target_name[63 - 8 * i -: 8]);
        end
    end

    always_comb begin
        unique case (i_cfg.search_mode)
            MODE_ORDINAL: match = (i_cfg.target_index != 15'd0)
                               && (cnt_inc == {1'b0, i_cfg.target_index});
            MODE_FILE:    match = (i_entry.entry_name == i_cfg.target_name)
                               && (i_entry.entry_ext == i_cfg.target_ext);
            MODE_PREFIX:  match = is_dir && (&byte_ok);
            default:      match = 1'b0;
        endcase
    end

    always_comb begin
        o_state = cur;
        report  = 1'b0;
        o_result.status = STATUS_SKIPPED;
        priority if (cur.search_closed) begin
            o_result.status = STATUS_CLOSED;
        end else if (first_byte == END_MARK) begin
            o_result.status       = STATUS_END;
            o_state.search_closed = 1'b1;
        end else begin
            if (counted) begin
                o_state.entry_counter = cnt_inc;
                o_state.byte_total    = total_inc;
                if (i_cfg.search_mode == MODE_LIST) begin
                    o_result.status = STATUS_LISTED;
                    report          = 1'b1;
                end else if (match) begin
                    o_result.status       = STATUS_FOUND;
                    report                = 1'b1;
                    o_state.search_closed = 1'b1;
                end
            end
            if (i_entry.last_in_directory) begin
                if (!report) begin
                    o_result.status = STATUS_EXHAUSTED;
                end
                o_state.search_closed = 1'b1;
            end
        end
        o_result.first_cluster   = report ? {i_entry.cluster_high, i_entry.cluster_low}
                                          : 32'd0;
        o_result.file_size       = report ? i_entry.entry_size : 32'd0;
        o_result.is_directory    = report && is_dir;
        o_result.entries_counted = o_state.entry_counter;
        o_result.total_bytes     = o_state.byte_total;
    end

endmodule

>>> hdl/fat32_directory_entry_search.sv
// A word passes the input register, then the result register. Throughput, unless
// stalled: one entry word per cycle; the input register feeds the evaluation
// logic and the search state updates as the word moves into the result register.
// Reset (synchronous, active low) empties both stages, clears counter, total and
// closed flag, and loads the register defaults (prefix length eight, rest zero).
`timescale 1ns / 1ps

module fat32_directory_entry_search (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [fds_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [fds_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    fds_entry_if.sink                          i_entry,
    fds_result_if.source                       o_result
);
    import fds_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    logic    r_s1_valid;
    t_entry  r_s1;
    logic    r_out_valid;
    t_result r_out;

    t_state  n_state;
    t_result n_out;
    t_entry  in_word;
    logic    advance;
    logic    take_in;

    assign in_word = '{
        start_search:      i_entry.start_search,
        last_in_directory: i_entry.last_in_directory,
        entry_name:        i_entry.entry_name,
        entry_ext:         i_entry.entry_ext,
        entry_attrib:      i_entry.entry_attrib,
        cluster_high:      i_entry.cluster_high,
        cluster_low:       i_entry.cluster_low,
        entry_size:        i_entry.entry_size
    };

    // Move stage one forward when the result register is free or drains
    assign advance       = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_entry.ready = !r_s1_valid || advance;
    assign take_in       = i_entry.valid && i_entry.ready;

    fds_eval u_eval (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_entry  (r_s1),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{
                search_mode:   MODE_ORDINAL,
                target_index:  15'd0,
                target_name:   64'd0,
                target_ext:    24'd0,
                prefix_length: PREFIX_RESET
            };
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SEARCH_MODE:   r_cfg.search_mode   <= i_cfg_wdata[1:0];
                CFG_TARGET_INDEX:  r_cfg.target_index  <= i_cfg_wdata[14:0];
                CFG_TARGET_NAME:   r_cfg.target_name   <= i_cfg_wdata;
                CFG_TARGET_EXT:    r_cfg.target_ext    <= i_cfg_wdata[23:0];
                CFG_PREFIX_LENGTH: r_cfg.prefix_length <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (take_in) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_s1 <= in_word;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.status          = r_out.status;
    assign o_result.first_cluster   = r_out.first_cluster;
    assign o_result.file_size       = r_out.file_size;
    assign o_result.is_directory    = r_out.is_directory;
    assign o_result.entries_counted = r_out.entries_counted;
    assign o_result.total_bytes     = r_out.total_bytes;

endmodule

>>> hdl/fds_checker.sv
// Port-level assertions for the directory entry search, bound to the top level.
`timescale 1ns / 1ps

module fds_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_status,
    input logic [31:0] i_first_cluster,
    input logic [31:0] i_file_size,
    input logic        i_is_directory
);
    import fds_pkg::*;

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status <= STATUS_CLOSED))
        else $error("status code out of range");

    // Entry fields are zero unless the entry was found or listed
    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status != STATUS_FOUND && i_status != STATUS_LISTED)
        |-> (i_first_cluster == 32'd0 && i_file_size == 32'd0 && !i_is_directory))
        else $error("entry fields set on a word that was not reported");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_status)))
        else $error("stalled result word changed");

endmodule

bind fat32_directory_entry_search fds_checker u_fds_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_status        (o_result.status),
    .i_first_cluster (o_result.first_cluster),
    .i_file_size     (o_result.file_size),
    .i_is_directory  (o_result.is_directory)
);

>>> verif/fat32_directory_entry_search_tb.sv
// Self-checking testbench for the FAT32 directory entry search block.
`timescale 1ns / 1ps

module fat32_directory_entry_search_tb;
    import fds_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;

    // Predicts the result word of every accepted entry word and checks the DUT output.
    class dir_search_checker;
        logic [1:0]  mode;
        logic [14:0] tgt_index;
        logic [63:0] tgt_name;
        logic [23:0] tgt_ext;
        logic [3:0]  pfx_len;
        logic [15:0] counter;
        logic [31:0] total;
        bit          closed;
        t_result     awaited_results[$];
        int          errors;
        int          results_seen;
        int          status_seen[8];

        function new();
            mode      = MODE_ORDINAL;
            tgt_index = '0;
            tgt_name  = '0;
            tgt_ext   = '0;
            pfx_len   = PREFIX_RESET;
            counter   = '0;
            total     = '0;
            closed    = 1'b0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] data);
            case (idx)
                CFG_SEARCH_MODE:   mode = data[1:0];
                CFG_TARGET_INDEX:  tgt_index = data[14:0];
                CFG_TARGET_NAME:   tgt_name = data;
                CFG_TARGET_EXT:    tgt_ext = data[23:0];
                CFG_PREFIX_LENGTH: pfx_len = data[3:0];
                default: ;
            endcase
        endfunction

        function void note_entry(t_entry e);
            t_result     r;
            logic [7:0]  lead;
            logic [63:0] mask;
            int          plen;
            bit          hit;
            bit          report;
            r      = '0;
            hit    = 1'b0;
            report = 1'b0;
            if (e.start_search) begin
                counter = '0;
                total   = '0;
                closed  = 1'b0;
            end
            lead = e.entry_name[63:56];
            if (closed) begin
                r.status = STATUS_CLOSED;
            end else if (lead == END_MARK) begin
                r.status = STATUS_END;
                closed   = 1'b1;
            end else begin
                r.status = STATUS_SKIPPED;
                if (lead != DELETED_MARK && (e.entry_attrib & ATTR_KIND_MASK) == 8'h00) begin
                    counter = counter + 16'd1;
                    total   = total + e.entry_size;
                    case (mode)
                        MODE_ORDINAL: hit = tgt_index != '0 && counter == {1'b0, tgt_index};
                        MODE_FILE:    hit = e.entry_name == tgt_name && e.entry_ext == tgt_ext;
                        MODE_PREFIX: begin
                            plen = (pfx_len > 4'd8) ? 8 : int'(pfx_len);
                            mask = (plen == 0) ? 64'h0 : ({64{1'b1}} << (8 * (8 - plen)));
                            hit  = e.entry_attrib[ATTR_DIR_BIT]
                                && ((e.entry_name ^ tgt_name) & mask) == 64'h0;
                        end
                        default: ;
                    endcase
                    if (mode == MODE_LIST) begin
                        r.status = STATUS_LISTED;
                        report   = 1'b1;
                    end else if (hit) begin
                        r.status = STATUS_FOUND;
                        report   = 1'b1;
                        closed   = 1'b1;
                    end
                end
                if (e.last_in_directory) begin
                    if (!report)
                        r.status = STATUS_EXHAUSTED;
                    closed = 1'b1;
                end
            end
            if (report) begin
                r.first_cluster = {e.cluster_high, e.cluster_low};
                r.file_size     = e.entry_size;
                r.is_directory  = e.entry_attrib[ATTR_DIR_BIT];
            end
            r.entries_counted = counter;
            r.total_bytes     = total;
            awaited_results.push_back(r);
        endfunction

        function void cmp(string fld, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (awaited_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, status %0d", $time, got.status);
                return;
            end
            want = awaited_results.pop_front();
            results_seen++;
            status_seen[want.status]++;
            cmp("status", 64'(want.status), 64'(got.status));
            cmp("first_cluster", 64'(want.first_cluster), 64'(got.first_cluster));
            cmp("file_size", 64'(want.file_size), 64'(got.file_size));
            cmp("is_directory", 64'(want.is_directory), 64'(got.is_directory));
            cmp("entries_counted", 64'(want.entries_counted), 64'(got.entries_counted));
            cmp("total_bytes", 64'(want.total_bytes), 64'(got.total_bytes));
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;

    fds_entry_if  ent_if ();
    fds_result_if res_if ();

    fat32_directory_entry_search dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_entry     (ent_if.sink),
        .o_result    (res_if.source)
    );

    dir_search_checker sb;
    bit send_idle_en;
    bit recv_idle_en;
    bit hold_req;
    int words_sent;
    int quiet_cycles;
    logic [1:0] mode_order[4] = '{MODE_ORDINAL, MODE_FILE, MODE_PREFIX, MODE_LIST};

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Check before noting, so a stray result never pairs with a word accepted on the same edge.
    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                r = {res_if.status, res_if.first_cluster, res_if.file_size,
                     res_if.is_directory, res_if.entries_counted, res_if.total_bytes};
                sb.check_result(r);
            end
            if (ent_if.valid && ent_if.ready)
                sb.note_entry({ent_if.start_search, ent_if.last_in_directory,
                               ent_if.entry_name, ent_if.entry_ext, ent_if.entry_attrib,
                               ent_if.cluster_high, ent_if.cluster_low, ent_if.entry_size});
        end
    end

    always @(posedge i_clk) begin
        if ((ent_if.valid && ent_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     sb.awaited_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    // Result receiver: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!recv_idle_en) begin
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= 17);
            end
        end
    end

    task automatic send_entry(t_entry e);
        if (send_idle_en && $urandom_range(0, 99) < 17) begin
            ent_if.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        ent_if.valid             <= 1'b1;
        ent_if.start_search      <= e.start_search;
        ent_if.last_in_directory <= e.last_in_directory;
        ent_if.entry_name        <= e.entry_name;
        ent_if.entry_ext         <= e.entry_ext;
        ent_if.entry_attrib      <= e.entry_attrib;
        ent_if.cluster_high      <= e.cluster_high;
        ent_if.cluster_low       <= e.cluster_low;
        ent_if.entry_size        <= e.entry_size;
        @(posedge i_clk);
        while (!ent_if.ready) @(posedge i_clk);
        words_sent++;
    endtask

    // Drop valid and wait until every result word has come back.
    task automatic drain();
        ent_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.awaited_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_config(t_cfg c);
        drain();
        write_reg(CFG_SEARCH_MODE, 64'(c.search_mode));
        write_reg(CFG_TARGET_INDEX, 64'(c.target_index));
        write_reg(CFG_TARGET_NAME, c.target_name);
        write_reg(CFG_TARGET_EXT, 64'(c.target_ext));
        write_reg(CFG_PREFIX_LENGTH, 64'(c.prefix_length));
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_cfg mk_cfg(logic [1:0] mode, logic [14:0] idx, logic [63:0] name,
                                    logic [23:0] ext, logic [3:0] plen);
        t_cfg c;
        c.search_mode   = mode;
        c.target_index  = idx;
        c.target_name   = name;
        c.target_ext    = ext;
        c.prefix_length = plen;
        return c;
    endfunction

    function automatic t_entry mk_entry(bit start, bit last, logic [63:0] name,
                                        logic [23:0] ext, logic [7:0] attrib,
                                        logic [31:0] size);
        t_entry e;
        e.start_search      = start;
        e.last_in_directory = last;
        e.entry_name        = name;
        e.entry_ext         = ext;
        e.entry_attrib      = attrib;
        e.cluster_high      = 16'($urandom);
        e.cluster_low       = 16'($urandom);
        e.entry_size        = size;
        return e;
    endfunction

    function automatic t_cfg rand_cfg(int ph);
        t_cfg c;
        int   p;
        c.search_mode = mode_order[ph % 4];
        p = $urandom_range(0, 3);
        c.target_index = (p == 0) ? 15'h0 : (p == 1) ? 15'h7FFF : 15'($urandom_range(1, 12));
        c.target_name = ($urandom_range(0, 5) == 0) ? {64{1'b1}} : {$urandom, $urandom};
        if (c.target_name[63:56] == END_MARK || c.target_name[63:56] == DELETED_MARK)
            c.target_name[63:56] = "S";
        p = $urandom_range(0, 3);
        c.target_ext = (p == 0) ? 24'h0 : (p == 1) ? 24'hFFFFFF : 24'($urandom);
        c.prefix_length = 4'($urandom_range(0, 15));
        return c;
    endfunction

    function automatic t_entry noise_entry();
        t_entry e;
        e = {$urandom, $urandom, $urandom, $urandom, $urandom, 2'b00};
        e.start_search      = 1'($urandom);
        e.last_in_directory = 1'($urandom);
        return e;
    endfunction

    // Mostly plausible entries, biased toward the current search target.
    function automatic t_entry rand_entry();
        t_entry      e;
        logic [63:0] mask;
        int          pick;
        int          plen;
        e = mk_entry(1'b0, 1'b0, {$urandom, $urandom}, 24'($urandom),
                     8'($urandom) & 8'hF0, $urandom);
        if ($urandom_range(0, 99) < 12)
            e.entry_attrib[3:0] = 4'($urandom_range(1, 15));
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            e.entry_name[63:56] = DELETED_MARK;
        end else if (pick < 30) begin
            e.entry_name = sb.tgt_name;
            if ($urandom_range(0, 3) != 0)
                e.entry_ext = sb.tgt_ext;
        end else if (pick < 45) begin
            plen = $urandom_range(0, 8);
            mask = (plen == 0) ? 64'h0 : ({64{1'b1}} << (8 * (8 - plen)));
            e.entry_name = (sb.tgt_name & mask) | (e.entry_name & ~mask);
            e.entry_attrib[ATTR_DIR_BIT] = 1'b1;
        end
        if (e.entry_name[63:56] == END_MARK)
            e.entry_name[63:56] = "A";
        return e;
    endfunction

    task automatic send_directory(int len);
        t_entry e;
        int     tail;
        for (int k = 0; k < len; k++) begin
            e = ($urandom_range(0, 99) < 8) ? noise_entry() : rand_entry();
            if ($urandom_range(0, 99) >= 8) begin
                e.start_search      = (k == 0);
                e.last_in_directory = 1'b0;
            end
            if (k == len - 1) begin
                tail = $urandom_range(0, 99);
                if (tail < 45)
                    e.last_in_directory = 1'b1;
                else if (tail < 75)
                    e.entry_name[63:56] = END_MARK;
            end
            send_entry(e);
        end
    endtask

    initial begin
        t_entry e;
        int     phase_start;
        sb           = new();
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        hold_req     = 1'b0;
        words_sent   = 0;
        quiet_cycles = 0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_wdata  = '0;
        ent_if.valid = 1'b0;
        ent_if.start_search      = 1'b0;
        ent_if.last_in_directory = 1'b0;
        ent_if.entry_name        = '0;
        ent_if.entry_ext         = '0;
        ent_if.entry_attrib      = '0;
        ent_if.cluster_high      = '0;
        ent_if.cluster_low       = '0;
        ent_if.entry_size        = '0;
        res_if.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: ordinal mode with index zero never finds anything.
        e = mk_entry(1'b1, 1'b0, {64{1'b1}}, 24'hFFFFFF, 8'hF0, 32'hFFFFFFFF);
        e.cluster_high = 16'hFFFF;
        e.cluster_low  = 16'hFFFF;
        send_entry(e);
        send_entry(mk_entry(1'b0, 1'b0, {DELETED_MARK, 56'h0}, 24'h0, 8'h00, 32'h10));
        send_entry(mk_entry(1'b0, 1'b0, "LONGNAME", "   ", 8'h0F, 32'h20));
        send_entry(mk_entry(1'b0, 1'b1, "LASTONE ", "BIN", 8'h00, 32'h1));
        send_entry(mk_entry(1'b0, 1'b0, "AFTER   ", "BIN", 8'h00, 32'h5));
        send_entry(mk_entry(1'b1, 1'b0, 64'h0, 24'h0, 8'h00, 32'h0));
        send_entry(mk_entry(1'b0, 1'b0, "CLOSED  ", "BIN", 8'h00, 32'h5));

        apply_config(mk_cfg(MODE_ORDINAL, 15'd2, 64'h0, 24'h0, PREFIX_RESET));
        send_entry(mk_entry(1'b1, 1'b0, "ONE     ", "DAT", 8'h00, 32'h100));
        send_entry(mk_entry(1'b0, 1'b0, "TWO     ", "DAT", 8'h10, 32'h200));
        send_entry(mk_entry(1'b0, 1'b0, "THREE   ", "DAT", 8'h00, 32'h300));

        apply_config(mk_cfg(MODE_FILE, 15'd0, "README  ", "TXT", PREFIX_RESET));
        send_entry(mk_entry(1'b1, 1'b0, "README  ", "TXT", 8'h20, 32'h400));
        send_entry(mk_entry(1'b1, 1'b0, "README  ", "TXX", 8'h20, 32'h400));
        send_entry(mk_entry(1'b0, 1'b0, "README  ", "TXT", 8'h01, 32'h400));
        send_entry(mk_entry(1'b0, 1'b1, "README  ", "TXT", 8'h00, 32'h400));

        apply_config(mk_cfg(MODE_PREFIX, 15'd0, "SUBDIR  ", "   ", 4'd0));
        send_entry(mk_entry(1'b1, 1'b0, "PLAIN   ", "TXT", 8'h00, 32'h7));
        send_entry(mk_entry(1'b0, 1'b0, "ANYDIR  ", "   ", 8'h10, 32'h0));
        apply_config(mk_cfg(MODE_PREFIX, 15'd0, "SUBDIR  ", "   ", 4'd15));
        send_entry(mk_entry(1'b1, 1'b0, "SUBDIRX ", "   ", 8'h10, 32'h0));
        send_entry(mk_entry(1'b0, 1'b0, "SUBDIR  ", "   ", 8'h10, 32'h0));
        apply_config(mk_cfg(MODE_PREFIX, 15'd0, "SUBDIR  ", "   ", 4'd3));
        send_entry(mk_entry(1'b1, 1'b0, "SUBQWERT", "   ", 8'h10, 32'h0));

        apply_config(mk_cfg(MODE_LIST, 15'h7FFF, {64{1'b1}}, 24'hFFFFFF, 4'd8));
        send_entry(mk_entry(1'b1, 1'b0, "FIRST   ", "DAT", 8'h00, 32'h11));
        send_entry(mk_entry(1'b0, 1'b0, {DELETED_MARK, 56'h0}, "DAT", 8'h00, 32'h22));
        send_entry(mk_entry(1'b0, 1'b1, "SECOND  ", "DAT", 8'h10, 32'h33));
        send_entry(mk_entry(1'b0, 1'b0, "THIRD   ", "DAT", 8'h00, 32'h44));
        send_entry(mk_entry(1'b1, 1'b1, "LFNPART ", "   ", 8'h0F, 32'h55));

        for (int ph = 0; ph < 12; ph++) begin
            apply_config(rand_cfg(ph));
            send_idle_en = (ph != 3);
            recv_idle_en = (ph != 3);
            if (ph == 5)
                hold_req = 1'b1;
            phase_start = words_sent;
            while (words_sent - phase_start < 115) begin
                if ($urandom_range(0, 9) == 0)
                    send_entry(noise_entry());
                send_directory($urandom_range(3, 16));
            end
        end

        drain();
        repeat (10) @(posedge i_clk);

        $display("Run covered %0d entry words and %0d result words over all four search modes",
                 words_sent, sb.results_seen);
        $display("Statuses: skipped %0d, found %0d, listed %0d, end %0d, exhausted %0d, closed %0d",
                 sb.status_seen[STATUS_SKIPPED], sb.status_seen[STATUS_FOUND],
                 sb.status_seen[STATUS_LISTED], sb.status_seen[STATUS_END],
                 sb.status_seen[STATUS_EXHAUSTED], sb.status_seen[STATUS_CLOSED]);
        if (sb.errors == 0 && sb.awaited_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
